// ----- design/kcc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and key codes for the keypad calculator control unit.
// ----------------------------------------------------------------------------
package kcc_pkg;

    localparam int OUT_WIDTH = 32;

    // ASCII key codes
    localparam logic [7:0] KEY_ZERO  = 8'd48;
    localparam logic [7:0] KEY_NINE  = 8'd57;
    localparam logic [7:0] KEY_NONE  = 8'h6E;  // 'n'
    localparam logic [7:0] KEY_CLEAR = 8'h3F;  // '?'
    localparam logic [7:0] KEY_EQUAL = 8'h3D;  // '='
    localparam logic [7:0] KEY_ADD   = 8'h2B;  // '+'
    localparam logic [7:0] KEY_SUB   = 8'h2D;  // '-'
    localparam logic [7:0] KEY_MUL   = 8'h2A;  // '*'
    localparam logic [7:0] KEY_DIV   = 8'h2F;  // '/'

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        K_NONE,
        K_DIGIT,
        K_OPER,
        K_EQUAL,
        K_CLEAR,
        K_OTHER
    } t_key_kind;

    typedef struct packed {
        t_key_kind  kind;
        logic [3:0] digit;
        t_op        op;
    } t_key_info;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_FIX
    } t_alu_state;

endpackage : kcc_pkg
`default_nettype wire

// ----- design/kcc_key_dec.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcc_key_dec
// Classify one ASCII key into digit, operator, equals, clear, none or other.
// ----------------------------------------------------------------------------
module kcc_key_dec
    import kcc_pkg::*;
(
    input  wire logic [7:0] i_key,
    output t_key_info       o_info
);

    always_comb begin
        o_info.kind  = K_OTHER;
        o_info.digit = i_key[3:0];
        o_info.op    = OP_NONE;
        priority if (i_key >= KEY_ZERO && i_key <= KEY_NINE) begin
            o_info.kind = K_DIGIT;
        end else if (i_key == KEY_NONE) begin
            o_info.kind = K_NONE;
        end else if (i_key == KEY_CLEAR) begin
            o_info.kind = K_CLEAR;
        end else if (i_key == KEY_EQUAL) begin
            o_info.kind = K_EQUAL;
        end else if (i_key == KEY_ADD) begin
            o_info.kind = K_OPER;
            o_info.op   = OP_ADD;
        end else if (i_key == KEY_SUB) begin
            o_info.kind = K_OPER;
            o_info.op   = OP_SUB;
        end else if (i_key == KEY_MUL) begin
            o_info.kind = K_OPER;
            o_info.op   = OP_MUL;
        end else if (i_key == KEY_DIV) begin
            o_info.kind = K_OPER;
            o_info.op   = OP_DIV;
        end else begin
            o_info.kind = K_OTHER;
        end
    end

endmodule : kcc_key_dec
`default_nettype wire

// ----- design/kcc_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kcc_alu
// Arithmetic unit: registered add/sub, bit-serial shift-add multiply and
// bit-serial restoring divide (truncating toward zero), one bit per cycle.
// ----------------------------------------------------------------------------
module kcc_alu
    import kcc_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire t_op                   i_op,
    input  wire logic [WORD_WIDTH-1:0] i_left,
    input  wire logic [WORD_WIDTH-1:0] i_right,
    output logic                       o_done,
    output logic [WORD_WIDTH-1:0]      o_result
);

    localparam int CW = $clog2(WORD_WIDTH + 1);

    t_alu_state            r_state, n_state;
    t_op                   r_op;
    logic [CW-1:0]         r_cnt;
    logic [WORD_WIDTH-1:0] r_a;    // multiplicand / dividend-quotient shifter
    logic [WORD_WIDTH-1:0] r_b;    // multiplier shifter / divisor
    logic [WORD_WIDTH-1:0] r_acc;  // product / partial remainder
    logic                  r_neg;
    logic [WORD_WIDTH-1:0] r_res;
    logic                  r_done;

    logic [WORD_WIDTH+1:0] w_trial;
    logic [WORD_WIDTH-1:0] w_mag_l, w_mag_r;

    assign w_trial = {1'b0, r_acc, r_a[WORD_WIDTH-1]} - {2'b00, r_b};
    assign w_mag_l = i_left[WORD_WIDTH-1]  ? (~i_left + 1'b1)  : i_left;
    assign w_mag_r = i_right[WORD_WIDTH-1] ? (~i_right + 1'b1) : i_right;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            A_IDLE: begin
                if (i_start && i_op == OP_MUL) begin
                    n_state = A_MUL;
                end else if (i_start && i_op == OP_DIV) begin
                    n_state = A_DIV;
                end
            end
            A_MUL, A_DIV: begin
                if (r_cnt == CW'(1)) begin
                    n_state = A_FIX;
                end
            end
            A_FIX:   n_state = A_IDLE;
            default: n_state = A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_start && (i_op == OP_ADD || i_op == OP_SUB)) begin
                        r_done <= 1'b1;
                    end
                end
                A_FIX:   r_done <= 1'b1;
                default: r_done <= 1'b0;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            A_IDLE: begin
                if (i_start) begin
                    r_op  <= i_op;
                    r_cnt <= CW'(WORD_WIDTH);
                    r_acc <= '0;
                    r_neg <= i_left[WORD_WIDTH-1] ^ i_right[WORD_WIDTH-1];
                    unique case (i_op)
                        OP_ADD: r_res <= i_left + i_right;
                        OP_SUB: r_res <= i_left - i_right;
                        OP_MUL: begin
                            r_a <= i_left;
                            r_b <= i_right;
                        end
                        OP_DIV: begin
                            r_a <= w_mag_l;
                            r_b <= w_mag_r;
                        end
                        default: r_res <= r_res;
                    endcase
                end
            end
            A_MUL: begin
                if (r_b[0]) begin
                    r_acc <= r_acc + r_a;
                end
                r_a   <= {r_a[WORD_WIDTH-2:0], 1'b0};
                r_b   <= {1'b0, r_b[WORD_WIDTH-1:1]};
                r_cnt <= r_cnt - 1'b1;
            end
            A_DIV: begin
                if (!w_trial[WORD_WIDTH+1]) begin
                    r_acc <= w_trial[WORD_WIDTH-1:0];
                    r_a   <= {r_a[WORD_WIDTH-2:0], 1'b1};
                end else begin
                    r_acc <= {r_acc[WORD_WIDTH-2:0], r_a[WORD_WIDTH-1]};
                    r_a   <= {r_a[WORD_WIDTH-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
            end
            A_FIX: begin
                if (r_op == OP_DIV) begin
                    r_res <= r_neg ? (~r_a + 1'b1) : r_a;
                end else begin
                    r_res <= r_acc;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule : kcc_alu
`default_nettype wire

// ----- design/keypad_calculator_control_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keypad_calculator_control_unit
// Four-function keypad calculator control: builds operands from digit keys,
// latches an operator, and evaluates on equals with chaining.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  key in  | i_valid / o_stall  | i_key
//  result  | o_valid / i_stall  | o_result, o_entry_value, o_entering_second,
//          |                    | o_result_valid, o_div_by_zero
//
//  Flow: digit, operator, clear and unknown keys are decoded, then load the
//  output register; equals with an operator runs in kcc_alu first, as a
//  registered add or subtract for + and -, or in the bit-serial shift-add
//  multiplier and restoring divider for * and /; equals with no operator or a
//  zero divisor goes straight to the output register. The no-key code gives no result.
//  Reset: synchronous, active low; clears operands, flags, accumulator and
//  the output valid.
//  Stalls: a key is taken while a previous result still waits in the output
//  register; the new result holds in S_EMIT until that register drains.
// ----------------------------------------------------------------------------
module keypad_calculator_control_unit
    import kcc_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // key transaction
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [7:0]        i_key,
    // result transaction
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic signed [31:0]     o_result,
    output logic signed [31:0]     o_entry_value,
    output logic                   o_entering_second,
    output logic                   o_result_valid,
    output logic                   o_div_by_zero
);

    // calculator state
    t_state                r_state, n_state;
    logic                  r_second;
    t_op                   r_op;
    logic                  r_chain;
    logic                  r_locked;
    logic [WORD_WIDTH-1:0] r_first;
    logic [WORD_WIDTH-1:0] r_sec;
    logic [WORD_WIDTH-1:0] r_acc;
    logic                  r_flag_valid;
    logic                  r_flag_dz;

    // output register
    logic                  r_out_valid;
    logic [31:0]           r_out_result;
    logic [31:0]           r_out_entry;
    logic                  r_out_second;
    logic                  r_out_rvalid;
    logic                  r_out_dz;

    t_key_info             w_info;
    logic                  w_accept;
    logic                  w_out_load;
    logic                  w_alu_start;
    logic                  w_alu_done;
    logic [WORD_WIDTH-1:0] w_alu_res;
    logic [WORD_WIDTH-1:0] w_left;
    logic [WORD_WIDTH-1:0] w_entry;
    logic [WORD_WIDTH-1:0] w_entry_x10;
    logic                  w_div_zero;
    logic [31:0]           w_acc32;
    logic [31:0]           w_entry32;

    kcc_key_dec u_key_dec (
        .i_key  (i_key),
        .o_info (w_info)
    );

    kcc_alu #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_alu_start),
        .i_op     (r_op),
        .i_left   (w_left),
        .i_right  (r_sec),
        .o_done   (w_alu_done),
        .o_result (w_alu_res)
    );

    assign w_accept   = i_valid && !o_stall;
    assign w_left     = r_chain ? r_acc : r_first;
    assign w_entry    = r_second ? r_sec : r_first;
    assign w_div_zero = (r_op == OP_DIV) && (r_sec == '0);

    // value * 10 + digit as (value << 3) + (value << 1) + digit
    assign w_entry_x10 = {w_entry[WORD_WIDTH-4:0], 3'b000}
                       + {w_entry[WORD_WIDTH-2:0], 1'b0}
                       + {{(WORD_WIDTH-4){1'b0}}, w_info.digit};

    // fit the internal word to the 32-bit result ports
    generate
        if (WORD_WIDTH >= OUT_WIDTH) begin : g_trunc
            assign w_acc32   = r_acc[OUT_WIDTH-1:0];
            assign w_entry32 = w_entry[OUT_WIDTH-1:0];
        end else begin : g_sext
            assign w_acc32   = {{(OUT_WIDTH-WORD_WIDTH){r_acc[WORD_WIDTH-1]}}, r_acc};
            assign w_entry32 = {{(OUT_WIDTH-WORD_WIDTH){w_entry[WORD_WIDTH-1]}}, w_entry};
        end
    endgenerate

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_info.kind != K_NONE) begin
                    if (w_info.kind == K_EQUAL && r_op != OP_NONE && !w_div_zero) begin
                        n_state = S_CALC;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_CALC: begin
                if (w_alu_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state machine outputs
    always_comb begin
        o_stall     = (r_state != S_IDLE);
        w_out_load  = (r_state == S_EMIT) && (!r_out_valid || !i_stall);
        w_alu_start = (r_state == S_IDLE) && w_accept && (w_info.kind == K_EQUAL)
                      && (r_op != OP_NONE) && !w_div_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_second     <= 1'b0;
            r_op         <= OP_NONE;
            r_chain      <= 1'b0;
            r_locked     <= 1'b0;
            r_first      <= '0;
            r_sec        <= '0;
            r_acc        <= '0;
            r_flag_valid <= 1'b0;
            r_flag_dz    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && w_accept && w_info.kind != K_NONE) begin
                r_flag_valid <= 1'b0;
                r_flag_dz    <= 1'b0;
                unique case (w_info.kind)
                    K_DIGIT: begin
                        if (r_second) begin
                            r_sec <= w_entry_x10;
                        end else begin
                            r_first <= w_entry_x10;
                        end
                    end
                    K_CLEAR: begin
                        r_second <= 1'b0;
                        r_first  <= '0;
                        r_sec    <= '0;
                        r_locked <= 1'b0;
                        r_chain  <= 1'b0;
                    end
                    K_EQUAL: begin
                        // release the lock; a zero divisor holds the result
                        r_locked  <= 1'b0;
                        r_flag_dz <= w_div_zero;
                    end
                    K_OPER: begin
                        if (!r_locked) begin
                            r_op     <= w_info.op;
                            r_second <= 1'b1;
                            if (r_chain) begin
                                r_sec <= '0;
                            end
                        end
                        r_locked <= 1'b1;
                    end
                    default: r_locked <= r_locked;
                endcase
            end
            if (r_state == S_CALC && w_alu_done) begin
                r_acc        <= w_alu_res;
                r_chain      <= 1'b1;
                r_flag_valid <= 1'b1;
            end
        end
    end

    // output register: load on emit, drop when downstream takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_result <= w_acc32;
            r_out_entry  <= w_entry32;
            r_out_second <= r_second;
            r_out_rvalid <= r_flag_valid;
            r_out_dz     <= r_flag_dz;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result          = r_out_result;
    assign o_entry_value     = r_out_entry;
    assign o_entering_second = r_out_second;
    assign o_result_valid    = r_out_rvalid;
    assign o_div_by_zero     = r_out_dz;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_alu_done |-> r_state == S_CALC)
        else $error("arithmetic unit finished outside of a calculation");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_result_valid && o_div_by_zero))
        else $error("result valid and divide by zero both set");

    a_none_key_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_key == KEY_NONE) |=> r_state == S_IDLE)
        else $error("no-key code started a transaction");

    a_lock_implies_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked |-> r_second)
        else $error("operator locked while entering the first operand");

endmodule : keypad_calculator_control_unit
`default_nettype wire

// ----- verif/keypad_calculator_control_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_calculator_control_unit_tb
// Self-checking bench for the keypad calculator: queues key presses, predicts
// every readout from its own copy of the calculator state, and checks each
// result transaction field by field under changing idle and stall patterns.
// ----------------------------------------------------------------------------
module keypad_calculator_control_unit_tb;
    import kcc_pkg::*;

    // Hold the receiver off this long once, so the block fills and stalls.
    localparam int HOLD_CYCLES = 400;
    // End the run after this many cycles without any transaction.
    localparam int STALL_LIMIT = 3000;
    // Let a slow multiply or divide finish before the final verdict.
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [31:0] result;
        logic [31:0] entry;
        logic        second;
        logic        res_valid;
        logic        dz;
    } t_calc_out;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic [7:0]        i_key   = 8'd0;
    logic              i_stall = 1'b0;
    logic              o_stall;
    logic              o_valid;
    logic signed [31:0] o_result;
    logic signed [31:0] o_entry_value;
    logic              o_entering_second;
    logic              o_result_valid;
    logic              o_div_by_zero;

    // Key presses waiting to be offered, and readouts waiting to arrive.
    logic [7:0] pending_keys[$];
    t_calc_out  expected_readout[$];

    // Calculator state as the bench sees it; starts at the reset values.
    bit          second_entry = 1'b0;
    t_op         latched_op   = OP_NONE;
    bit          chained      = 1'b0;
    bit          op_lock      = 1'b0;
    logic [31:0] lhs          = 32'd0;
    logic [31:0] rhs          = 32'd0;
    logic [31:0] acc          = 32'd0;

    // Traffic shaping, set per phase by the stimulus block.
    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    bit hold_done     = 1'b0;
    int hold_left     = 0;

    bit key_taken   = 1'b0;
    int idle_cycles = 0;
    int mismatches  = 0;
    int queued      = 0;

    logic [7:0] op_keys[4]    = '{KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV};
    logic [7:0] loose_keys[8] = '{KEY_ADD, KEY_SUB, KEY_MUL, KEY_DIV,
                                  KEY_EQUAL, KEY_CLEAR, KEY_NONE, KEY_NINE};
    // Operands at the edges of the word: max positive, wraps to min, wraps to -1, and zero.
    string wide_operands[4] = '{"2147483647", "2147483648", "4294967295", "0"};

    keypad_calculator_control_unit uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_key             (i_key),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_result          (o_result),
        .o_entry_value     (o_entry_value),
        .o_entering_second (o_entering_second),
        .o_result_valid    (o_result_valid),
        .o_div_by_zero     (o_div_by_zero)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Calculator prediction. Advance the state by one key press and return 1
    // with the readout the block must show, or 0 for the no-key code.
    // ------------------------------------------------------------------------
    function automatic bit calc_press(input logic [7:0] key, output t_calc_out readout);
        logic [31:0] left;
        logic [31:0] value;
        logic [31:0] mag_l;
        logic [31:0] mag_r;
        logic [31:0] quo;
        bit          ok;
        bit          dz;
        t_op         pressed;
        ok      = 1'b0;
        dz      = 1'b0;
        pressed = OP_NONE;
        readout = '0;
        if (key == KEY_NONE)
            return 1'b0;
        if (key >= KEY_ZERO && key <= KEY_NINE) begin
            // Append the digit to whichever operand is being typed; wrap at 32 bits.
            if (second_entry)
                rhs = rhs * 32'd10 + 32'(key - KEY_ZERO);
            else
                lhs = lhs * 32'd10 + 32'(key - KEY_ZERO);
        end else if (key == KEY_CLEAR) begin
            // Clear keeps the accumulator and the last operator.
            second_entry = 1'b0;
            lhs          = 32'd0;
            rhs          = 32'd0;
            op_lock      = 1'b0;
            chained      = 1'b0;
        end else if (key == KEY_EQUAL) begin
            left  = chained ? acc : lhs;
            value = acc;
            case (latched_op)
                OP_ADD: begin
                    value = left + rhs;
                    ok    = 1'b1;
                end
                OP_SUB: begin
                    value = left - rhs;
                    ok    = 1'b1;
                end
                OP_MUL: begin
                    value = left * rhs;
                    ok    = 1'b1;
                end
                OP_DIV: begin
                    if (rhs == 32'd0) begin
                        // Hold the accumulator and flag the attempt.
                        dz = 1'b1;
                    end else begin
                        // Divide magnitudes, then fix the sign: truncates toward
                        // zero, and min / -1 wraps back to min.
                        mag_l = left[31] ? -left : left;
                        mag_r = rhs[31] ? -rhs : rhs;
                        quo   = mag_l / mag_r;
                        value = (left[31] ^ rhs[31]) ? -quo : quo;
                        ok    = 1'b1;
                    end
                end
                default: ;
            endcase
            if (ok) begin
                acc     = value;
                chained = 1'b1;
            end
            op_lock = 1'b0;
        end else begin
            case (key)
                KEY_ADD: pressed = OP_ADD;
                KEY_SUB: pressed = OP_SUB;
                KEY_MUL: pressed = OP_MUL;
                KEY_DIV: pressed = OP_DIV;
                default: pressed = OP_NONE;
            endcase
            // Take the first operator only; after a result the running value
            // becomes the left side, so drop the old second operand.
            if (pressed != OP_NONE) begin
                if (!op_lock) begin
                    latched_op   = pressed;
                    second_entry = 1'b1;
                    if (chained)
                        rhs = 32'd0;
                end
                op_lock = 1'b1;
            end
        end
        readout.result    = acc;
        readout.entry     = second_entry ? rhs : lhs;
        readout.second    = second_entry;
        readout.res_valid = ok;
        readout.dz        = dz;
        return 1'b1;
    endfunction

    task automatic report(input string field, input logic [31:0] want_v, got_v);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                 $time, field, $signed(want_v), $signed(got_v));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building. Each press of a real key counts toward the total.
    // ------------------------------------------------------------------------
    task automatic push_key(input logic [7:0] key);
        pending_keys.push_back(key);
        if (key != KEY_NONE)
            queued++;
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++)
            push_key(s[k]);
    endtask

    // Type an operand: mostly short, sometimes long enough to wrap, sometimes
    // empty, sometimes one of the edge values.
    task automatic push_operand();
        int sel;
        int len;
        sel = $urandom_range(99);
        if (sel < 8) begin
            push_text(wide_operands[$urandom_range(3)]);
        end else begin
            len = (sel < 18) ? $urandom_range(12, 8) : ((sel < 26) ? 0 : $urandom_range(3, 1));
            repeat (len) push_key(8'(KEY_ZERO + $urandom_range(9)));
        end
    endtask

    // Mostly complete calculations with random content; the rest clears,
    // arbitrary codes and loose fragments.
    task automatic queue_random(input int count);
        int stop;
        int pick;
        stop = queued + count;
        while (queued < stop) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if ($urandom_range(2) == 0) begin
                    push_key(KEY_CLEAR);
                    push_operand();
                end
                push_key(op_keys[$urandom_range(3)]);
                if ($urandom_range(7) == 0)
                    push_key(op_keys[$urandom_range(3)]);
                push_operand();
                push_key(KEY_EQUAL);
                if ($urandom_range(3) == 0)
                    repeat ($urandom_range(3, 1)) push_key(KEY_EQUAL);
            end else if (pick < 78) begin
                push_key(KEY_CLEAR);
            end else if (pick < 90) begin
                push_key(8'($urandom_range(255)));
            end else begin
                repeat ($urandom_range(4, 1))
                    push_key($urandom_range(1) ? loose_keys[$urandom_range(7)]
                                               : 8'(KEY_ZERO + $urandom_range(9)));
            end
        end
    endtask

    // Wait until every key went in and every readout came back.
    task automatic drain();
        while (!(pending_keys.size() == 0 && !i_valid && expected_readout.size() == 0))
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Key driver: change inputs on the falling edge. Hold the key while it is
    // stalled; after a transaction, offer the next key or go idle.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || key_taken) begin
            if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_key   <= pending_keys.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Result-side stall: one long hold-off on request, random otherwise.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: sample both channels on the rising edge. Check the readout
    // against the oldest prediction first, then predict the key just taken.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_calc_out want;
        t_calc_out got;
        if (!i_rst_n) begin
            key_taken   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            key_taken <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (expected_readout.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: unexpected result transaction, expected none, actual %0d",
                             $time, o_result);
                end else begin
                    want = expected_readout.pop_front();
                    if (o_result !== want.result)
                        report("result", want.result, o_result);
                    if (o_entry_value !== want.entry)
                        report("entry_value", want.entry, o_entry_value);
                    if (o_entering_second !== want.second)
                        report("entering_second", 32'(want.second), 32'(o_entering_second));
                    if (o_result_valid !== want.res_valid)
                        report("result_valid", 32'(want.res_valid), 32'(o_result_valid));
                    if (o_div_by_zero !== want.dz)
                        report("div_by_zero", 32'(want.dz), 32'(o_div_by_zero));
                end
            end
            if (i_valid && !o_stall) begin
                if (calc_press(i_key, got))
                    expected_readout.push_back(got);
            end
            // Watchdog: any transaction on either side restarts the count.
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Directed presses, no idling.
        push_key(KEY_EQUAL);            // equals with no operator latched
        push_key(KEY_NONE);             // no key: no readout
        push_key(8'h00);                // unknown codes at both ends
        push_key(8'hFF);
        // Min divided by -1, with a second operator ignored while locked.
        push_text("2147483648/-4294967295=");
        push_key(KEY_EQUAL);            // repeat the last operation
        push_text("/0=?");              // divide by zero, then clear
        drain();

        // Random presses: no idling, then sender idle, receiver stalling, both.
        queue_random(500);
        drain();
        send_idle_pct = 82;
        queue_random(400);
        drain();
        send_idle_pct = 0;
        stall_pct     = 82;
        queue_random(400);
        drain();
        send_idle_pct = 18;
        stall_pct     = 18;
        queue_random(400);
        drain();

        // Long hold-off on the result side while keys keep coming.
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 1'b1;
        queue_random(250);
        drain();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
